FILE: hdl/ptp_pkg.sv
package ptp_pkg;

    // default sizes
    localparam int NUMBER_BITS_DEF = 31;
    localparam int QUEUE_DEPTH_DEF = 2;

    // characters the template uses
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_Q     = 8'h71;

    // element type codes
    localparam logic [2:0] TY_CHAR     = 3'd0;
    localparam logic [2:0] TY_SHORT    = 3'd1;
    localparam logic [2:0] TY_INT      = 3'd2;
    localparam logic [2:0] TY_LONG     = 3'd3;
    localparam logic [2:0] TY_UNSIGNED = 3'd4;

    // byte order codes
    localparam logic [1:0] ORD_NONE   = 2'd0;
    localparam logic [1:0] ORD_LITTLE = 2'd1;
    localparam logic [1:0] ORD_BIG    = 2'd2;

    // array kinds
    localparam logic [1:0] AK_NONE   = 2'd0;
    localparam logic [1:0] AK_FIXED  = 2'd1;
    localparam logic [1:0] AK_ARGS   = 2'd2;
    localparam logic [1:0] AK_STREAM = 2'd3;

    // type letter classes
    typedef enum logic [1:0] {
        TK_NONE   = 2'd0,
        TK_PLAIN  = 2'd1,
        TK_DIGITS = 2'd2
    } t_tkind;

    typedef enum logic [2:0] {
        ST_ITEM          = 3'd0,
        ST_EMPTY_END     = 3'd1,
        ST_BAD_TYPE      = 3'd2,
        ST_NO_BITDEPTH   = 3'd3,
        ST_BAD_BITDEPTH  = 3'd4,
        ST_NO_ENDIAN     = 3'd5,
        ST_BAD_ARRAY     = 3'd6,
        ST_BAD_AFTER_NUM = 3'd7
    } t_status;

    typedef enum logic [3:0] {
        PH_TYPE        = 4'd0,
        PH_UFIRST      = 4'd1,
        PH_UDIGITS     = 4'd2,
        PH_ENDIAN      = 4'd3,
        PH_POST_ENDIAN = 4'd4,
        PH_ARR_OPEN    = 4'd5,
        PH_ARR_NUM     = 4'd6,
        PH_LEN_UFIRST  = 4'd7,
        PH_LEN_UDIGITS = 4'd8,
        PH_LEN_END     = 4'd9,
        PH_LEN_WS      = 4'd10,
        PH_LEN_CLOSE   = 4'd11,
        PH_POST_ARRAY  = 4'd12,
        PH_COUNT       = 4'd13
    } t_phase;

    // one classified template character
    typedef struct packed {
        logic       is_zero;
        logic       is_ws;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_mark;
        logic [1:0] order;
        logic       is_lbr;
        logic       is_rbr;
        t_tkind     tkind;
        logic [2:0] ttype;
        logic [6:0] tdepth;
    } t_token;

    // fields of one item under construction
    typedef struct packed {
        logic [2:0]  elem_type;
        logic [1:0]  byte_order;
        logic [6:0]  bit_depth;
        logic [1:0]  array_kind;
        logic [30:0] array_length;
        logic [2:0]  length_type;
        logic [6:0]  length_bit_depth;
        logic [30:0] repeat_count;
    } t_pend;

    typedef struct packed {
        t_status status;
        t_pend   item;
        logic    last;
    } t_result;

    localparam t_pend PEND_RESET = '{
        elem_type:        TY_CHAR,
        byte_order:       ORD_NONE,
        bit_depth:        7'd0,
        array_kind:       AK_NONE,
        array_length:     31'd0,
        length_type:      TY_CHAR,
        length_bit_depth: 7'd0,
        repeat_count:     31'd1
    };

    // hop limit of one step through the phase chain
    localparam int HOPS = 8;

endpackage

FILE: hdl/ptp_fifo.sv
module ptp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    // depth is a power of two, at least 2
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hdl/ptp_front.sv
module ptp_front
    import ptp_pkg::*;
(
    input  logic [7:0] i_char,
    output t_token     o_token
);

    always_comb begin
        o_token          = '0;
        o_token.is_zero  = (i_char == CH_NUL);
        o_token.is_ws    = (i_char == CH_SPACE) || (i_char == CH_TAB) || (i_char == CH_LF);
        o_token.is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        o_token.digit    = i_char[3:0];
        o_token.is_mark  = (i_char == CH_LT) || (i_char == CH_GT);
        o_token.order    = (i_char == CH_LT) ? ORD_LITTLE : ORD_BIG;
        o_token.is_lbr   = (i_char == CH_LBR);
        o_token.is_rbr   = (i_char == CH_RBR);
        o_token.tkind    = TK_NONE;
        o_token.ttype    = TY_CHAR;
        o_token.tdepth   = 7'd0;
        unique case (i_char)
            CH_C: begin
                o_token.tkind = TK_PLAIN;
                o_token.ttype = TY_CHAR;
            end
            CH_S: begin
                o_token.tkind = TK_PLAIN;
                o_token.ttype = TY_SHORT;
            end
            CH_I: begin
                o_token.tkind = TK_PLAIN;
                o_token.ttype = TY_INT;
            end
            CH_L: begin
                o_token.tkind = TK_PLAIN;
                o_token.ttype = TY_LONG;
            end
            CH_B: begin
                o_token.tkind  = TK_PLAIN;
                o_token.ttype  = TY_UNSIGNED;
                o_token.tdepth = 7'd8;
            end
            CH_W: begin
                o_token.tkind  = TK_PLAIN;
                o_token.ttype  = TY_UNSIGNED;
                o_token.tdepth = 7'd16;
            end
            CH_D: begin
                o_token.tkind  = TK_PLAIN;
                o_token.ttype  = TY_UNSIGNED;
                o_token.tdepth = 7'd32;
            end
            CH_Q: begin
                o_token.tkind  = TK_PLAIN;
                o_token.ttype  = TY_UNSIGNED;
                o_token.tdepth = 7'd64;
            end
            CH_U: begin
                o_token.tkind = TK_DIGITS;
                o_token.ttype = TY_UNSIGNED;
            end
            default: begin
                o_token.tkind = TK_NONE;
            end
        endcase
    end

endmodule

FILE: hdl/ptp_back.sv
module ptp_back
    import ptp_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_token  i_tok,
    input  logic    i_tok_empty,
    output logic    o_tok_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    localparam int NB = NUMBER_BITS;
    localparam logic [NB-1:0] NUM_MAX = {NB{1'b1}};

    t_phase        r_phase, n_phase;
    t_pend         r_pend, n_pend;
    logic          r_pv, n_pv;
    logic [NB-1:0] r_acc, n_acc;
    logic          r_halted, n_halted;

    logic          s_rv;
    t_result       s_res;
    logic          consume;
    logic [NB-1:0] acc_grown;

    // saturating decimal accumulate
    function automatic logic [NB-1:0] acc_digit(input logic [NB-1:0] acc,
                                                 input logic [3:0]    dig);
        logic [NB+3:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (NB+4)'(dig);
        if (v > {4'b0000, NUM_MAX}) begin
            return NUM_MAX;
        end
        return v[NB-1:0];
    endfunction

    function automatic logic depth_ok(input logic [NB-1:0] d);
        return (d == NB'(8)) || (d == NB'(16)) || (d == NB'(32)) || (d == NB'(64));
    endfunction

    // a digit is only ever added to the accumulator in the first phase of a step, so the
    // accumulator it grows is always the registered one
    assign acc_grown = acc_digit(r_acc, i_tok.digit);

    // next state: walks the phase chain for one character
    always_comb begin : step_comb
        logic    done;
        logic    fl;
        t_status fcode;
        n_phase  = r_phase;
        n_pend   = r_pend;
        n_pv     = r_pv;
        n_acc    = r_acc;
        n_halted = r_halted;
        s_rv     = 1'b0;
        s_res    = '0;
        done     = 1'b0;
        fl       = 1'b0;
        fcode    = ST_ITEM;
        if (r_halted) begin
            done = 1'b1;
            if (i_tok.is_zero) begin
                n_halted = 1'b0;
            end
        end
        for (int hop = 0; hop < HOPS; hop++) begin
            if (!done) begin
                unique case (n_phase)
                    PH_TYPE: begin
                        done = 1'b1;
                        if (i_tok.is_ws) begin
                            // skip
                        end else if (i_tok.is_zero) begin
                            s_rv         = 1'b1;
                            s_res.status = n_pv ? ST_ITEM : ST_EMPTY_END;
                            s_res.item   = n_pv ? n_pend : '0;
                            s_res.last   = 1'b1;
                            n_phase      = PH_TYPE;
                            n_pv         = 1'b0;
                            n_pend       = PEND_RESET;
                            n_acc        = '0;
                        end else if (i_tok.tkind == TK_NONE) begin
                            fl    = 1'b1;
                            fcode = ST_BAD_TYPE;
                        end else begin
                            if (n_pv) begin
                                s_rv         = 1'b1;
                                s_res.status = ST_ITEM;
                                s_res.item   = n_pend;
                                s_res.last   = 1'b0;
                            end
                            n_pv             = 1'b1;
                            n_pend           = PEND_RESET;
                            n_pend.elem_type = i_tok.ttype;
                            n_pend.bit_depth = i_tok.tdepth;
                            n_acc            = '0;
                            n_phase = (i_tok.tkind == TK_DIGITS) ? PH_UFIRST : PH_ENDIAN;
                        end
                    end
                    PH_UFIRST, PH_LEN_UFIRST: begin
                        done = 1'b1;
                        if (!i_tok.is_digit) begin
                            fl    = 1'b1;
                            fcode = ST_NO_BITDEPTH;
                        end else begin
                            n_acc   = NB'(i_tok.digit);
                            n_phase = (n_phase == PH_UFIRST) ? PH_UDIGITS : PH_LEN_UDIGITS;
                        end
                    end
                    PH_UDIGITS, PH_LEN_UDIGITS: begin
                        if (i_tok.is_digit) begin
                            done  = 1'b1;
                            n_acc = acc_grown;
                        end else if (!depth_ok(n_acc)) begin
                            done  = 1'b1;
                            fl    = 1'b1;
                            fcode = ST_BAD_BITDEPTH;
                        end else if (n_phase == PH_UDIGITS) begin
                            n_pend.bit_depth = n_acc[6:0];
                            n_phase          = PH_ENDIAN;
                        end else begin
                            n_pend.length_bit_depth = n_acc[6:0];
                            n_phase                 = PH_LEN_END;
                        end
                    end
                    PH_ENDIAN: begin
                        if (i_tok.is_ws) begin
                            done = 1'b1;
                        end else if (i_tok.is_mark) begin
                            done              = 1'b1;
                            n_pend.byte_order = i_tok.order;
                            n_phase           = PH_POST_ENDIAN;
                        end else if (n_pend.elem_type == TY_UNSIGNED
                                     && n_pend.bit_depth != 7'd8) begin
                            done  = 1'b1;
                            fl    = 1'b1;
                            fcode = ST_NO_ENDIAN;
                        end else begin
                            n_phase = PH_POST_ENDIAN;
                        end
                    end
                    PH_POST_ENDIAN: begin
                        if (i_tok.is_ws) begin
                            done = 1'b1;
                        end else if (i_tok.is_lbr) begin
                            done    = 1'b1;
                            n_phase = PH_ARR_OPEN;
                        end else begin
                            n_phase = PH_POST_ARRAY;
                        end
                    end
                    PH_ARR_OPEN: begin
                        done = 1'b1;
                        if (i_tok.is_digit) begin
                            n_pend.array_kind = AK_FIXED;
                            n_acc             = NB'(i_tok.digit);
                            n_phase           = PH_ARR_NUM;
                        end else if (i_tok.is_rbr) begin
                            n_pend.array_kind = AK_ARGS;
                            n_phase           = PH_POST_ARRAY;
                        end else if (i_tok.tkind == TK_NONE) begin
                            fl    = 1'b1;
                            fcode = ST_BAD_ARRAY;
                        end else begin
                            n_pend.array_kind       = AK_STREAM;
                            n_pend.length_type      = i_tok.ttype;
                            n_pend.length_bit_depth = i_tok.tdepth;
                            n_phase = (i_tok.tkind == TK_DIGITS) ? PH_LEN_UFIRST : PH_LEN_END;
                        end
                    end
                    PH_ARR_NUM: begin
                        done = 1'b1;
                        if (i_tok.is_digit) begin
                            n_acc = acc_grown;
                        end else if (!i_tok.is_rbr) begin
                            fl    = 1'b1;
                            fcode = ST_BAD_AFTER_NUM;
                        end else begin
                            n_pend.array_length = 31'(n_acc);
                            n_phase             = PH_POST_ARRAY;
                        end
                    end
                    PH_LEN_END, PH_LEN_WS: begin
                        done = 1'b1;
                        if (i_tok.is_mark) begin
                            n_phase = PH_LEN_CLOSE;
                        end else if (i_tok.is_ws) begin
                            n_phase = PH_LEN_WS;
                        end else if (n_pend.length_type == TY_UNSIGNED
                                     && n_pend.length_bit_depth != 7'd8) begin
                            fl    = 1'b1;
                            fcode = ST_NO_ENDIAN;
                        end else if (n_phase == PH_LEN_END && i_tok.is_rbr) begin
                            n_phase = PH_POST_ARRAY;
                        end else begin
                            fl    = 1'b1;
                            fcode = ST_BAD_AFTER_NUM;
                        end
                    end
                    PH_LEN_CLOSE: begin
                        done = 1'b1;
                        if (!i_tok.is_rbr) begin
                            fl    = 1'b1;
                            fcode = ST_BAD_AFTER_NUM;
                        end else begin
                            n_phase = PH_POST_ARRAY;
                        end
                    end
                    PH_POST_ARRAY: begin
                        if (i_tok.is_ws) begin
                            done = 1'b1;
                        end else if (i_tok.is_digit) begin
                            done    = 1'b1;
                            n_acc   = NB'(i_tok.digit);
                            n_phase = PH_COUNT;
                        end else begin
                            n_phase = PH_TYPE;
                        end
                    end
                    PH_COUNT: begin
                        if (i_tok.is_digit) begin
                            done  = 1'b1;
                            n_acc = acc_grown;
                        end else begin
                            n_pend.repeat_count = 31'(n_acc);
                            n_phase             = PH_TYPE;
                        end
                    end
                    default: begin
                        n_phase = PH_TYPE;
                    end
                endcase
            end
        end
        // error: report, drop the item and ignore up to the terminator
        if (fl) begin
            s_rv         = 1'b1;
            s_res.status = fcode;
            s_res.item   = '0;
            s_res.last   = 1'b1;
            n_phase      = PH_TYPE;
            n_pv         = 1'b0;
            n_pend       = PEND_RESET;
            n_acc        = '0;
            n_halted     = !i_tok.is_zero;
        end
    end

    // outputs: one character per cycle while the result queue has room
    always_comb begin
        consume    = !i_tok_empty && !i_res_full;
        o_tok_pop  = consume;
        o_res_push = consume && s_rv;
        o_res      = s_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TYPE;
            r_pend   <= PEND_RESET;
            r_pv     <= 1'b0;
            r_acc    <= '0;
            r_halted <= 1'b0;
        end else if (consume) begin
            r_phase  <= n_phase;
            r_pend   <= n_pend;
            r_pv     <= n_pv;
            r_acc    <= n_acc;
            r_halted <= n_halted;
        end
    end

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.status != ST_ITEM) |-> o_res.last)
        else $error("non-item result without last");

    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.status != ST_ITEM) |-> (o_res.item == '0))
        else $error("non-item result carries item fields");

    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_halted) |-> !o_res_push)
        else $error("result produced while skipping after an error");

    a_halt_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.status != ST_ITEM && o_res.status != ST_EMPTY_END
         && !i_tok.is_zero) |=> r_halted)
        else $error("error did not start skipping");

endmodule

FILE: hdl/pack_template_parser.sv
// Binary-pack template parser. Template characters arrive one per beat on the
// push/full side, with byte 0 ending a template; parsed items and status codes
// leave on the empty/pop side, oldest first. The front classifies each
// character (whitespace, digit, endian mark, bracket, type letter) and writes
// it into a small token queue; the back pulls one token per cycle, walks the
// parse phases and writes at most one result per token into the result queue.
// Throughput is one character per clock as long as results are popped; the
// back holds its token whenever the result queue is full, even for a character
// that gives no result. The token of the character completing a result waits in
// the registered token queue, and the result is written into the registered
// result queue, whose oldest entry drives the output ports.
// An item is reported when the next type letter or the terminator arrives.
// After an error the back drops every character up to and including the next
// 0 without a result. Number fields saturate at 2^NUMBER_BITS - 1.
module pack_template_parser
    import ptp_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_template_char,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [2:0]  o_elem_type,
    output logic [1:0]  o_byte_order,
    output logic [6:0]  o_bit_depth,
    output logic [1:0]  o_array_kind,
    output logic [30:0] o_array_length,
    output logic [2:0]  o_length_type,
    output logic [6:0]  o_length_bit_depth,
    output logic [30:0] o_repeat_count,
    output logic        o_last
);

    localparam int TOK_W = $bits(t_token);
    localparam int RES_W = $bits(t_result);

    t_token  front_tok;     // classified character, before the queue
    t_token  back_tok;      // oldest queued token
    logic    tok_empty;
    logic    tok_pop;
    logic    res_full;
    logic    res_push;
    t_result res_in;
    t_result res_out;

    // front: classify the incoming character
    ptp_front u_front (
        .i_char  (i_template_char),
        .o_token (front_tok)
    );

    // token queue between front and back
    ptp_fifo #(
        .WIDTH (TOK_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_tok_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_tok),
        .o_full  (full),
        .i_pop   (tok_pop),
        .o_data  (back_tok),
        .o_empty (tok_empty)
    );

    // back: phase machine, pending item and digit accumulator
    ptp_back #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (back_tok),
        .i_tok_empty (tok_empty),
        .o_tok_pop   (tok_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // result queue, seen by the user as the output side
    ptp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    // unpack the oldest result onto the ports
    assign o_status           = res_out.status;
    assign o_elem_type        = res_out.item.elem_type;
    assign o_byte_order       = res_out.item.byte_order;
    assign o_bit_depth        = res_out.item.bit_depth;
    assign o_array_kind       = res_out.item.array_kind;
    assign o_array_length     = res_out.item.array_length;
    assign o_length_type      = res_out.item.length_type;
    assign o_length_bit_depth = res_out.item.length_bit_depth;
    assign o_repeat_count     = res_out.item.repeat_count;
    assign o_last             = res_out.last;

endmodule
